FILE: hdl/kwm_pkg.sv
// Shared types, codes and defaults for the k-way sorted merge block.
package kwm_pkg;

    localparam int NUM_LISTS_DEF  = 8;
    localparam int LIST_DEPTH_DEF = 64;

    localparam logic [1:0] FN_APPEND = 2'd0;
    localparam logic [1:0] FN_POP    = 2'd1;
    localparam logic [1:0] FN_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DRAIN,
        S_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]         func;
        logic [2:0]         list_id;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic [2:0]         source_list;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic cand_vld;
    } t_cmp_ctl;

endpackage

FILE: hdl/kwm_mem.sv
// List storage RAM: one write port, one registered read port.
module kwm_mem #(
    parameter int AW = 9
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic signed [31:0]   i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output logic signed [31:0]   o_rdata
);

    logic signed [31:0] r_mem [2**AW];
    logic signed [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/kwm_cmp.sv
// Shared signed comparator holding the running minimum head of a scan.
module kwm_cmp #(
    parameter int LW = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kwm_pkg::t_cmp_ctl   i_ctl,
    input  logic signed [31:0]  i_cand_val,
    input  logic [LW-1:0]       i_cand_k,
    output logic                o_found,
    output logic signed [31:0]  o_best_val,
    output logic [LW-1:0]       o_best_k
);

    logic               r_found;
    logic signed [31:0] r_best_val;
    logic [LW-1:0]      r_best_k;
    logic               take;

    // strict less-than keeps the lowest index on ties
    assign take = i_ctl.cand_vld && (!r_found || (i_cand_val < r_best_val));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.start) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_ctl.start && take) begin
            r_best_val <= i_cand_val;
            r_best_k   <= i_cand_k;
        end
    end

    assign o_found    = r_found;
    assign o_best_val = r_best_val;
    assign o_best_k   = r_best_k;

endmodule

FILE: hdl/k_way_sorted_merge_top.sv
// Top level of the k-way sorted merge: sequencer, list counters, RAM and comparator.
// Append, clear and unused codes: S_EXEC, then S_DONE, which moves the result to the output register.
// Pop: S_EXEC, S_SCAN over every list, S_DRAIN, S_FIN, S_DONE; a new request is taken only back in S_IDLE.
// One list head compared per cycle by the shared comparator; output stalls hold the result in S_DONE.
// Synchronous active-low reset empties all lists and the output register.
// List RAM contents are not cleared; only entries below a list's fill count are read.
module k_way_sorted_merge_top #(
    parameter int NUM_LISTS  = kwm_pkg::NUM_LISTS_DEF,
    parameter int LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  kwm_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output kwm_pkg::t_out_item o_out
);

    localparam int LW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int PW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int AW = LW + PW;

    kwm_pkg::t_state    r_state, n_state;
    logic [1:0]         r_func;
    logic [2:0]         r_lid;
    logic signed [31:0] r_val;
    logic [LW-1:0]      r_k;
    logic               r_p_vld;
    logic [LW-1:0]      r_p_k;
    kwm_pkg::t_out_item r_res, n_res;
    logic               r_out_vld;
    kwm_pkg::t_out_item r_out;

    logic [CW-1:0]      r_fill [NUM_LISTS];
    logic [CW-1:0]      r_head [NUM_LISTS];

    logic [CW-1:0]      cur_fill;
    logic [CW-1:0]      cur_head;
    logic               nonempty;
    logic               lid_ok;
    logic               append_ok;
    logic               mem_we;
    logic signed [31:0] mem_rdata;
    logic               clr_all;
    logic               inc_fill;
    logic               inc_head;
    logic               load_out;
    logic               accept;
    kwm_pkg::t_cmp_ctl  cmp_ctl;
    logic               best_found;
    logic signed [31:0] best_val;
    logic [LW-1:0]      best_k;

    assign cur_fill  = r_fill[r_k];
    assign cur_head  = r_head[r_k];
    assign nonempty  = cur_head < cur_fill;
    assign lid_ok    = {29'd0, r_lid} < 32'(NUM_LISTS);
    assign append_ok = lid_ok && (cur_fill < CW'(LIST_DEPTH));
    assign accept    = i_in_valid && !o_in_stall;

    kwm_mem #(
        .AW(AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr ({r_k, cur_fill[PW-1:0]}),
        .i_wdata (r_val),
        .i_raddr ({r_k, cur_head[PW-1:0]}),
        .o_rdata (mem_rdata)
    );

    kwm_cmp #(
        .LW(LW)
    ) u_cmp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (cmp_ctl),
        .i_cand_val (mem_rdata),
        .i_cand_k   (r_p_k),
        .o_found    (best_found),
        .o_best_val (best_val),
        .o_best_k   (best_k)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= kwm_pkg::S_IDLE;
            r_out_vld <= 1'b0;
            r_p_vld   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= load_out || (r_out_vld && i_out_stall);
            r_p_vld   <= (r_state == kwm_pkg::S_SCAN) && nonempty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_k <= r_k;
        r_res <= n_res;
        if (load_out) begin
            r_out <= r_res;
        end
        if (accept) begin
            r_func <= i_in.func;
            r_lid  <= i_in.list_id;
            r_val  <= i_in.value;
            r_k    <= (i_in.func == kwm_pkg::FN_APPEND) ? LW'(i_in.list_id) : '0;
        end else if (r_state == kwm_pkg::S_SCAN) begin
            r_k <= r_k + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_LISTS; i++) begin
            if (!i_rst_n || clr_all) begin
                r_fill[i] <= '0;
                r_head[i] <= '0;
            end else begin
                if (inc_fill && (r_k == LW'(i))) begin
                    r_fill[i] <= r_fill[i] + 1'b1;
                end
                if (inc_head && (best_k == LW'(i))) begin
                    r_head[i] <= r_head[i] + 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_state          = r_state;
        n_res            = r_res;
        cmp_ctl.start    = 1'b0;
        cmp_ctl.cand_vld = r_p_vld;
        mem_we           = 1'b0;
        clr_all          = 1'b0;
        inc_fill         = 1'b0;
        inc_head         = 1'b0;
        load_out         = 1'b0;
        unique case (r_state)
            kwm_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = kwm_pkg::S_EXEC;
                end
            end
            kwm_pkg::S_EXEC: begin
                n_res   = '0;
                n_state = kwm_pkg::S_DONE;
                unique case (r_func)
                    kwm_pkg::FN_APPEND: begin
                        if (append_ok) begin
                            mem_we   = 1'b1;
                            inc_fill = 1'b1;
                        end else begin
                            n_res.status = kwm_pkg::ST_FULL;
                        end
                    end
                    kwm_pkg::FN_POP: begin
                        cmp_ctl.start = 1'b1;
                        n_state       = kwm_pkg::S_SCAN;
                    end
                    kwm_pkg::FN_CLEAR: begin
                        clr_all = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            kwm_pkg::S_SCAN: begin
                if (r_k == LW'(NUM_LISTS - 1)) begin
                    n_state = kwm_pkg::S_DRAIN;
                end
            end
            kwm_pkg::S_DRAIN: begin
                n_state = kwm_pkg::S_FIN;
            end
            kwm_pkg::S_FIN: begin
                n_res   = '0;
                n_state = kwm_pkg::S_DONE;
                if (best_found) begin
                    inc_head          = 1'b1;
                    n_res.out_value   = best_val;
                    n_res.source_list = 3'(best_k);
                end else begin
                    n_res.status = kwm_pkg::ST_EMPTY;
                end
            end
            kwm_pkg::S_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = kwm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kwm_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != kwm_pkg::S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_head_le_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kwm_pkg::S_SCAN) |-> (r_head[r_k] <= r_fill[r_k]))
        else $error("head pointer passed fill count");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kwm_pkg::S_EXEC) |-> (r_fill[r_k] <= CW'(LIST_DEPTH)))
        else $error("fill count beyond list depth");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == kwm_pkg::S_DONE) && (!r_out_vld || !i_out_stall))
        |=> (r_out_vld && (r_state == kwm_pkg::S_IDLE)))
        else $error("finished result not moved to output");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status != kwm_pkg::ST_OK))
        |-> ((o_out.out_value == 32'sd0) && (o_out.source_list == 3'd0)))
        else $error("non-ok result carries data");
`endif

endmodule
